### design/seeded_xorshift128plus_generator_unit_assert.svh
// Assertion shorthands used by the generator's top-level RTL file.
`ifndef SEEDED_XORSHIFT128PLUS_GENERATOR_UNIT_ASSERT_SVH
`define SEEDED_XORSHIFT128PLUS_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SXG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SXG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sxg_pkg.sv
`default_nettype none

package sxg_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB = 2'd0,
    OP_FINISH = 2'd1,
    OP_DRAW   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_WARM
  } state_e;

  // FNV-1a 128-bit offset basis
  localparam logic [127:0] HASH_BASIS = 128'h6c62272e07bb0142_62b821756295c58d;

  // prime is 2^88 + 0x13B; 0x13B has bits 8,5,4,3,1,0 set
  localparam int unsigned PRIME_HI_SHIFT = 88;
  localparam int unsigned MUL_TERMS      = 6;
  localparam int unsigned TERM_W         = 3;

  localparam int unsigned WARM_W = 11;
  localparam logic [WARM_W-1:0] WARMUP_STEPS = 11'd128;

  localparam int unsigned XS_A = 23;
  localparam int unsigned XS_B = 18;
  localparam int unsigned XS_C = 5;

  typedef struct packed {
    logic absorb;
    logic clear;
  } hash_cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
  } unit_sts_t;

  typedef struct packed {
    logic load;
    logic step;
  } xs_cmd_t;

  // shift of each low term of the prime
  function automatic logic [3:0] term_shift(input logic [TERM_W-1:0] idx);
    logic [3:0] sh;
    case (idx)
      3'd0:    sh = 4'd0;
      3'd1:    sh = 4'd1;
      3'd2:    sh = 4'd3;
      3'd3:    sh = 4'd4;
      3'd4:    sh = 4'd5;
      3'd5:    sh = 4'd8;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

### design/seeded_xorshift128plus_generator_unit.sv
// Seeded xorshift128+ generator (shifts 23, 18, 5) with a 128-bit FNV-1a seed hash.
// Input channel: in_valid_i / in_stall_o with in_op_i and in_seed_byte_i.
//   absorb: XORs the byte into the hash and multiplies by 2^88 + 0x13B; the
//     product is built by one shared 128-bit adder over six shifted terms,
//     so an absorb word holds the block until all six terms are added.
//   finish: loads the hash into the generator, runs WARMUP_STEPS steps of the
//     step unit (one per cycle, 128 by default) and resets the hash; the block
//     is busy until the warm-up steps are done.
//   draw: advances the generator and returns the sum in the cycle after
//     acceptance on out_valid_o / out_random_value_o.
//   op 3 is taken and does nothing.
// Output channel: one registered word. While it waits under out_stall_i the
// block still takes absorb and finish words; a draw word is stalled until the
// output register is free or being emptied in that cycle.
// Reset: hash returns to the offset basis, generator state to zero, so draws
// before any seeding give zero.
`default_nettype none

`include "seeded_xorshift128plus_generator_unit_assert.svh"

module seeded_xorshift128plus_generator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_op_i,
  input  wire logic [7:0]  in_seed_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_random_value_o
);
  import sxg_pkg::*;

  state_e      state_q, state_d;
  logic        in_fire;
  logic        draw_fire;
  logic        out_valid_q;
  logic [63:0] out_value_q;
  logic [127:0] hash;
  logic [63:0]  sum;
  hash_cmd_t   hash_cmd;
  xs_cmd_t     xs_cmd;
  unit_sts_t   hash_sts;
  unit_sts_t   xs_sts;

  assign in_stall_o = (state_q != ST_IDLE) ||
                      ((op_e'(in_op_i) == OP_DRAW) && out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign draw_fire  = in_fire && (op_e'(in_op_i) == OP_DRAW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    hash_cmd.absorb = 1'b0;
    hash_cmd.clear  = 1'b0;
    xs_cmd.load     = 1'b0;
    xs_cmd.step     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_e'(in_op_i))
            OP_ABSORB: begin
              hash_cmd.absorb = 1'b1;
              state_d         = ST_ABSORB;
            end
            OP_FINISH: begin
              xs_cmd.load    = 1'b1;
              hash_cmd.clear = 1'b1;
              state_d        = (WARMUP_STEPS == '0) ? ST_IDLE : ST_WARM;
            end
            OP_DRAW: begin
              xs_cmd.step = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ABSORB: begin
        if (hash_sts.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_WARM: begin
        if (xs_sts.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  sxg_hash_mac u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (hash_cmd),
    .seed_byte_i (in_seed_byte_i),
    .hash_o      (hash),
    .sts_o       (hash_sts)
  );

  sxg_xs_core u_xs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (xs_cmd),
    .seed_i (hash),
    .sum_o  (sum),
    .sts_o  (xs_sts)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (draw_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_fire) begin
      out_value_q <= sum;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_random_value_o = out_value_q;

  `SXG_ASSERT_IMP(a_busy_stalls, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o,
    "input taken while busy")
  `SXG_ASSERT_NXT(a_draw_gives_word, clk_i, rst_ni, draw_fire, out_valid_q,
    "draw word gave no output")
  `SXG_ASSERT_IMP(a_mac_in_absorb, clk_i, rst_ni, hash_sts.busy, state_q == ST_ABSORB,
    "hash multiply running outside absorb")
  `SXG_ASSERT_IMP(a_warm_in_warm, clk_i, rst_ni, xs_sts.busy, state_q == ST_WARM,
    "warm-up running outside warm state")

endmodule

`default_nettype wire

### design/sxg_hash_mac.sv
`default_nettype none

module sxg_hash_mac (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sxg_pkg::hash_cmd_t cmd_i,
  input  wire logic [7:0]        seed_byte_i,
  output logic [127:0]           hash_o,
  output sxg_pkg::unit_sts_t     sts_o
);
  import sxg_pkg::*;

  logic [127:0]      hash_q, hash_d;
  logic [127:0]      base_q, base_d;
  logic [TERM_W-1:0] term_q, term_d;
  logic              busy_q, busy_d;
  logic              last_term;

  assign last_term = busy_q && (term_q == TERM_W'(MUL_TERMS - 1));

  always_comb begin
    hash_d = hash_q;
    base_d = base_q;
    term_d = term_q;
    busy_d = busy_q;
    if (cmd_i.absorb) begin
      base_d = {hash_q[127:8], hash_q[7:0] ^ seed_byte_i};
      // the 2^88 term needs no adder
      hash_d = base_d << PRIME_HI_SHIFT;
      term_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hash_d = hash_q + (base_q << term_shift(term_q));
      if (last_term) begin
        busy_d = 1'b0;
      end else begin
        term_d = term_q + 1'b1;
      end
    end else if (cmd_i.clear) begin
      hash_d = HASH_BASIS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_BASIS;
      term_q <= '0;
      busy_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      term_q <= term_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  assign hash_o    = hash_q;
  assign sts_o.busy = busy_q;
  assign sts_o.last = last_term;

endmodule

`default_nettype wire

### design/sxg_xs_core.sv
`default_nettype none

module sxg_xs_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sxg_pkg::xs_cmd_t cmd_i,
  input  wire logic [127:0]    seed_i,
  output logic [63:0]          sum_o,
  output sxg_pkg::unit_sts_t   sts_o
);
  import sxg_pkg::*;

  logic [63:0]       s0_q, s0_d;
  logic [63:0]       s1_q, s1_d;
  logic [WARM_W-1:0] warm_q, warm_d;
  logic [63:0]       x1;
  logic [63:0]       s_next;
  logic              warming;

  // one xorshift128+ step
  assign x1     = s0_q ^ (s0_q << XS_A);
  assign s_next = x1 ^ s1_q ^ (x1 >> XS_B) ^ (s1_q >> XS_C);
  assign sum_o  = s_next + s1_q;

  assign warming = (warm_q != '0);

  always_comb begin
    s0_d   = s0_q;
    s1_d   = s1_q;
    warm_d = warm_q;
    if (cmd_i.load) begin
      s0_d   = seed_i[63:0];
      s1_d   = seed_i[127:64];
      warm_d = WARMUP_STEPS;
    end else if (warming || cmd_i.step) begin
      s0_d = s1_q;
      s1_d = s_next;
      if (warming) begin
        warm_d = warm_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q   <= '0;
      s1_q   <= '0;
      warm_q <= '0;
    end else begin
      s0_q   <= s0_d;
      s1_q   <= s1_d;
      warm_q <= warm_d;
    end
  end

  assign sts_o.busy = warming;
  assign sts_o.last = (warm_q == WARM_W'(1));

endmodule

`default_nettype wire
